// ===== src/track_xy_angle_change_check_macros.svh =====
// Assertion macros used by the verification checker of the angle change block
`ifndef TRACK_XY_ANGLE_CHANGE_CHECK_MACROS_SVH
`define TRACK_XY_ANGLE_CHANGE_CHECK_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define TXA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("txa check failed");

// Clocked check that also holds across reset
`define TXA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("txa check failed");

`endif

// ===== src/trk_pkg.sv =====
// Package: widths, status codes, shared types and the CORDIC arctangent table
`default_nettype none

package trk_pkg;

    localparam int COORD_BITS   = 20;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    // CORDIC steps actually built (the table holds 24)
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    localparam int RATIO_BITS = 16;
    localparam int IN_BITS    = 8 * COORD_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = 1 + RATIO_BITS + 2;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

    // ratio_status codes
    localparam logic [1:0] STAT_FINITE = 2'd0;
    localparam logic [1:0] STAT_SAT    = 2'd1;
    localparam logic [1:0] STAT_UNDEF  = 2'd2;

    localparam logic [15:0] CHANGE_MAX_RST = 16'd512;

    // side information that rides along the divider stages
    typedef struct packed {
        logic                  special;
        logic                  compat;
        logic                  neg;
        logic [RATIO_BITS-1:0] value;
        logic [1:0]            status;
    } side_t;

    // atan(2^-i) in turns, full turn = 2^32
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/track_xy_angle_change_check.sv =====
// Top level: four-hit xy bend ratio check, fully pipelined
//
// Input stream (s_*): one transfer per candidate; s_tdata holds the eight hit
// coordinates, s_tuser the three-hit flag. Result stream (m_*): one transfer
// per candidate with compatible, ratio_value and ratio_status, in input order.
// change_max is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this.
// Throughput: one candidate per cycle while results are taken. Stages:
// input register, 17 CORDIC stages (pre-rotation plus 16 micro-rotations,
// three vectors in parallel), bend, magnitude/multiply, compare, 16 restoring
// divider stages, output register. The pipeline advances as a whole whenever
// the output register is empty or being taken; a stalled receiver freezes
// every stage and s_tready drops, so nothing is lost or repeated. Reset
// clears all valid bits and loads change_max with 2.0 (512 in Q8.8).
`default_nettype none

module track_xy_angle_change_check (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: hit_a_x, hit_a_y, hit_b_x, hit_b_y, hit_c_x, hit_c_y, hit_d_x, hit_d_y
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [trk_pkg::IN_BYTES*8-1:0]  s_tdata,
    // s_tuser: three_hit_pair
    input  wire logic                            s_tuser,
    // m_tdata: compatible, ratio_value[15:0], ratio_status[1:0], zero pad
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [trk_pkg::OUT_BYTES*8-1:0]      m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [15:0]                     cfg_wdata
);

    localparam int CB   = trk_pkg::COORD_BITS;
    localparam int CW   = CB + 1;
    localparam int AB   = trk_pkg::ANGLE_BITS;
    localparam int NS   = trk_pkg::CORDIC_N;
    localparam int QB   = trk_pkg::RATIO_BITS;
    localparam int NW   = AB + 10;
    localparam int DW   = AB + 1;
    localparam int CMPW = DW + QB;
    localparam int PIPE = NS + 5 + QB;
    localparam logic [31:0] RND  = 32'd1 << (31 - AB);
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

    logic        adv;
    logic [15:0] change_max_reg;
    logic [PIPE-1:0] vld_reg;
    logic [PIPE-1:0] fl_reg;
    logic        m_tvalid_reg;
    logic [trk_pkg::OUT_BYTES*8-1:0] m_tdata_reg;

    // whole pipeline moves when the output register can take a new result
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            change_max_reg <= trk_pkg::CHANGE_MAX_RST;
        end else if (cfg_we) begin
            change_max_reg <= cfg_wdata;
        end
    end

    // valid and flag chains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[PIPE-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fl_reg <= {fl_reg[PIPE-2:0], s_tuser};
        end
    end

    // stage 0: difference vectors b-a, c-b, d-c
    logic signed [CW-1:0] dx_reg [0:2];
    logic signed [CW-1:0] dy_reg [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_diff
        logic signed [CW-1:0] x0, y0, x1, y1;
        assign x0 = CW'($signed(s_tdata[(2*j)*CB +: CB]));
        assign y0 = CW'($signed(s_tdata[(2*j+1)*CB +: CB]));
        assign x1 = CW'($signed(s_tdata[(2*j+2)*CB +: CB]));
        assign y1 = CW'($signed(s_tdata[(2*j+3)*CB +: CB]));
        always_ff @(posedge aclk) begin
            if (adv) begin
                dx_reg[j] <= x1 - x0;
                dy_reg[j] <= y1 - y0;
            end
        end
    end

    // CORDIC azimuths, three lanes
    logic [31:0] z_w  [0:2];
    logic        zr_w [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_cor
        trk_cordic u_cordic (
            .aclk     (aclk),
            .en       (adv),
            .x_in     (dx_reg[j]),
            .y_in     (dy_reg[j]),
            .z_out    (z_w[j]),
            .zero_out (zr_w[j])
        );
    end

    // bend stage: round azimuths, wrap differences
    logic [AB-1:0] az [0:2];
    logic [31:0]   zr_sum [0:2];
    logic [AB-1:0] d1, d2;
    logic signed [AB:0] b1_reg, b2_reg;

    for (genvar j = 0; j < 3; j++) begin : g_az
        assign zr_sum[j] = z_w[j] + RND;
        assign az[j]     = zr_w[j] ? '0 : zr_sum[j][31 -: AB];
    end

    assign d1 = az[0] - az[1];
    assign d2 = az[1] - az[2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_reg <= (d1 > HALF) ? {1'b1, d1} : {1'b0, d1};
            b2_reg <= (d2 > HALF) ? {1'b1, d2} : {1'b0, d2};
        end
    end

    // magnitude and multiply stage
    logic signed [AB:0] nb1, nb2;
    logic [AB-1:0]      m1_reg, m2_reg;
    logic [AB+15:0]     c1_reg, c2_reg;
    logic               b1z_reg, b2z_reg, b1p_reg, b2p_reg, neg_reg;
    logic [AB-1:0]      m1_w, m2_w;

    assign nb1  = -b1_reg;
    assign nb2  = -b2_reg;
    assign m1_w = b1_reg[AB] ? nb1[AB-1:0] : b1_reg[AB-1:0];
    assign m2_w = b2_reg[AB] ? nb2[AB-1:0] : b2_reg[AB-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg  <= m1_w;
            m2_reg  <= m2_w;
            c1_reg  <= change_max_reg * m1_w;
            c2_reg  <= change_max_reg * m2_w;
            b1z_reg <= (b1_reg == '0);
            b2z_reg <= (b2_reg == '0);
            b1p_reg <= !b1_reg[AB] && (b1_reg != '0);
            b2p_reg <= !b2_reg[AB] && (b2_reg != '0);
            neg_reg <= b1_reg[AB] != b2_reg[AB];
        end
    end

    // compare stage: limit test, special cases, divider setup
    logic [NW-1:0]     rem_reg [0:QB];
    logic [DW-1:0]     den_reg [0:QB];
    logic [QB-1:0]     quo_reg [0:QB];
    logic              ovf_reg [0:QB];
    trk_pkg::side_t    sd_reg  [0:QB];

    logic [AB+15:0]    p1, p2;
    logic [NW-1:0]     num_w;
    logic [DW-1:0]     den_w;
    trk_pkg::side_t    sd_w;

    assign p1    = (AB+16)'({m1_reg, 8'd0});
    assign p2    = (AB+16)'({m2_reg, 8'd0});
    assign num_w = NW'({m1_reg, 9'd0}) + NW'(m2_reg);
    assign den_w = {m2_reg, 1'b0};

    always_comb begin
        sd_w.special = b1z_reg || b2z_reg;
        sd_w.neg     = neg_reg;
        sd_w.compat  = !(p1 > c2_reg) && !(p2 > c1_reg);
        sd_w.value   = '0;
        sd_w.status  = trk_pkg::STAT_FINITE;
        if (b2z_reg) begin
            sd_w.status = trk_pkg::STAT_SAT;
            if (b1z_reg) begin
                sd_w.compat = 1'b1;
                sd_w.status = trk_pkg::STAT_UNDEF;
            end else if (b1p_reg) begin
                sd_w.compat = 1'b0;
                sd_w.value  = 16'h7FFF;
            end else begin
                sd_w.compat = 1'b1;
                sd_w.value  = 16'h8000;
            end
        end else if (b1z_reg) begin
            sd_w.compat = !b2p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= num_w;
            den_reg[0] <= den_w;
            quo_reg[0] <= '0;
            ovf_reg[0] <= CMPW'(num_w) >= {den_w, QB'(0)};
            sd_reg[0]  <= sd_w;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int K = QB - j;
        logic [CMPW-1:0] sh;
        logic [CMPW-1:0] rx;
        logic            ge;
        assign sh = CMPW'(den_reg[j-1]) << K;
        assign rx = CMPW'(rem_reg[j-1]);
        assign ge = rx >= sh;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j] <= ge ? NW'(rx - sh) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (QB'(ge) << K);
                ovf_reg[j] <= ovf_reg[j-1];
                sd_reg[j]  <= sd_reg[j-1];
            end
        end
    end

    // output stage: saturation and result packing
    logic [QB-1:0] q_f, nq_f;
    logic          compat_o;
    logic [QB-1:0] value_o;
    logic [1:0]    status_o;

    assign q_f  = quo_reg[QB];
    assign nq_f = -q_f;

    always_comb begin
        compat_o = 1'b1;
        value_o  = '0;
        status_o = trk_pkg::STAT_FINITE;
        if (!fl_reg[PIPE-1]) begin
            compat_o = 1'b1;
        end else if (sd_reg[QB].special) begin
            compat_o = sd_reg[QB].compat;
            value_o  = sd_reg[QB].value;
            status_o = sd_reg[QB].status;
        end else if (!sd_reg[QB].neg) begin
            compat_o = sd_reg[QB].compat;
            if (ovf_reg[QB] || q_f[QB-1]) begin
                value_o  = 16'h7FFF;
                status_o = trk_pkg::STAT_SAT;
            end else begin
                value_o = q_f;
            end
        end else begin
            if (ovf_reg[QB] || (q_f[QB-1] && (q_f[QB-2:0] != '0))) begin
                value_o  = 16'h8000;
                status_o = trk_pkg::STAT_SAT;
            end else begin
                value_o = nq_f;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= (trk_pkg::OUT_BYTES*8)'({status_o, value_o, compat_o});
        end
    end

endmodule

`default_nettype wire

// ===== src/trk_cordic.sv =====
// Pipelined CORDIC vectoring unit: azimuth of one vector in 32-bit turns
`default_nettype none

module trk_cordic (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [trk_pkg::COORD_BITS:0] x_in,
    input  wire logic signed [trk_pkg::COORD_BITS:0] y_in,
    output logic        [31:0]                     z_out,
    output logic                                   zero_out
);

    localparam int CB = trk_pkg::COORD_BITS;
    localparam int XW = CB + 4;
    localparam int NS = trk_pkg::CORDIC_N;

    logic signed [XW-1:0] x_reg [0:NS];
    logic signed [XW-1:0] y_reg [0:NS];
    logic        [31:0]   z_reg [0:NS];
    logic                 zr_reg [0:NS];

    logic signed [XW-1:0] xe, ye;

    assign xe = {{3{x_in[CB]}}, x_in};
    assign ye = {{3{y_in[CB]}}, y_in};

    // pre-rotation by half a turn for the left half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            zr_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                x_reg[0] <= -xe;
                y_reg[0] <= -ye;
                z_reg[0] <= 32'h8000_0000;
            end else begin
                x_reg[0] <= xe;
                y_reg[0] <= ye;
                z_reg[0] <= 32'h0000_0000;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                zr_reg[i+1] <= zr_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + trk_pkg::atan_turn(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - trk_pkg::atan_turn(i);
                end
            end
        end
    end

    assign z_out    = z_reg[NS];
    assign zero_out = zr_reg[NS];

endmodule

`default_nettype wire

// ===== src/trk_checker.sv =====
// Port-level checker for the angle change block, bound to the top level
`default_nettype none
`include "track_xy_angle_change_check_macros.svh"

module trk_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [trk_pkg::OUT_BYTES*8-1:0]     m_tdata
);

    logic [1:0]  st;
    logic [15:0] val;

    assign st  = m_tdata[18:17];
    assign val = m_tdata[16:1];

    // a waiting result holds still
    `TXA_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // a blocked output stalls the input side
    `TXA_ASSERT(a_stall, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready)
    // nothing offered in the cycle after a reset cycle
    `TXA_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid)
    // zero over zero is accepted with a zero ratio
    `TXA_ASSERT(a_undef, aclk, aresetn, m_tvalid && st == trk_pkg::STAT_UNDEF |-> m_tdata[0] && val == 16'd0)

endmodule

bind track_xy_angle_change_check trk_checker u_trk_checker (.*);

`default_nettype wire
